@@ design/qdk_pkg.sv @@
// ----------------------------------------------------------------------------
// qdk_pkg - shared types and constants for the keyed-delete process queue
// Holds the record layout, request and status codes, sequencer states and
// the control structures that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package qdk_pkg;

	localparam int NAME_W     = 64;
	localparam int PRIO_W     = 8;
	localparam int PID_W      = 22;
	localparam int RUN_W      = 16;
	localparam int LEFT_W     = 5;
	localparam int NAME_BYTES = 8;

	typedef enum logic [1:0] {
		REQ_PUSH     = 2'd0,
		REQ_POP      = 2'd1,
		REQ_DEL_PID  = 2'd2,
		REQ_DEL_NAME = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SEARCH,
		S_SHIFT,
		S_RESP
	} seq_state_t;

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [PRIO_W-1:0] prio;
		logic [PID_W-1:0]  pid;
		logic [RUN_W-1:0]  runtime;
	} record_t;

	localparam int REC_W = $bits(record_t);

	// Datapath conditions seen by the sequencer.
	typedef struct packed {
		logic      in_fire;
		req_kind_t kind;
		logic      is_full;
		logic      is_empty;
		logic      pend;
		logic      hit;
		logic      more;
		logic      out_free;
	} ctrl_sts_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic    in_ready;
		logic    scan;
		logic    do_push;
		logic    capture;
		logic    shift_wr;
		logic    dec_count;
		logic    set_status;
		status_t status_val;
		logic    load_out;
	} ctrl_cmd_t;

	// Keeps the bytes of a name up to the first zero byte, within NAME_BYTES.
	function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] v);
		logic [NAME_W-1:0] r;
		logic              stop;
		r    = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i >= NAME_BYTES || v[8*i +: 8] == 8'd0) begin
				stop = 1'b1;
			end
			if (!stop) begin
				r[8*i +: 8] = v[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

@@ design/qdk_req_if.sv @@
// ----------------------------------------------------------------------------
// qdk_req_if - request channel of the keyed-delete process queue
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface qdk_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [qdk_pkg::NAME_W-1:0] in_name;
	logic [qdk_pkg::PRIO_W-1:0] in_priority;
	logic [qdk_pkg::PID_W-1:0]  in_pid;
	logic [qdk_pkg::RUN_W-1:0]  in_runtime;

	modport source (output valid, req_type, in_name, in_priority, in_pid, in_runtime,
		input ready);
	modport sink (input valid, req_type, in_name, in_priority, in_pid, in_runtime,
		output ready);
endinterface

@@ design/qdk_rsp_if.sv @@
// ----------------------------------------------------------------------------
// qdk_rsp_if - result channel of the keyed-delete process queue
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface qdk_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [qdk_pkg::NAME_W-1:0] out_name;
	logic [qdk_pkg::PRIO_W-1:0] out_priority;
	logic [qdk_pkg::PID_W-1:0]  out_pid;
	logic [qdk_pkg::RUN_W-1:0]  out_runtime;
	logic [qdk_pkg::LEFT_W-1:0] entries_left;

	modport source (output valid, status, out_name, out_priority, out_pid, out_runtime,
		entries_left, input ready);
	modport sink (input valid, status, out_name, out_priority, out_pid, out_runtime,
		entries_left, output ready);
endinterface

@@ design/qdk_ram.sv @@
// ----------------------------------------------------------------------------
// qdk_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qdk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/qdk_ctrl.sv @@
// ----------------------------------------------------------------------------
// qdk_ctrl - request sequencer of the keyed-delete process queue
// Steps each request from start through search and compaction, where it needs them, to result hand-off.
// ----------------------------------------------------------------------------
module qdk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  qdk_pkg::ctrl_sts_t sts,
	output qdk_pkg::ctrl_cmd_t cmd
);

	qdk_pkg::seq_state_t state_q;
	qdk_pkg::seq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qdk_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			qdk_pkg::S_IDLE: begin
				if (sts.in_fire) begin
					state_d = qdk_pkg::S_START;
				end
			end
			qdk_pkg::S_START: begin
				if (sts.kind == qdk_pkg::REQ_PUSH) begin
					state_d = qdk_pkg::S_RESP;
				end else if (sts.kind == qdk_pkg::REQ_POP && sts.is_empty) begin
					state_d = qdk_pkg::S_RESP;
				end else begin
					state_d = qdk_pkg::S_SEARCH;
				end
			end
			qdk_pkg::S_SEARCH: begin
				if (sts.pend && sts.hit) begin
					state_d = qdk_pkg::S_SHIFT;
				end else if (!sts.pend && !sts.more) begin
					state_d = qdk_pkg::S_RESP;
				end
			end
			qdk_pkg::S_SHIFT: begin
				if (!sts.pend && !sts.more) begin
					state_d = qdk_pkg::S_RESP;
				end
			end
			qdk_pkg::S_RESP: begin
				if (sts.out_free) begin
					state_d = qdk_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = qdk_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.status_val = qdk_pkg::ST_OK;
		case (state_q)
			qdk_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			qdk_pkg::S_START: begin
				if (sts.kind == qdk_pkg::REQ_PUSH) begin
					if (sts.is_full) begin
						cmd.set_status = 1'b1;
						cmd.status_val = qdk_pkg::ST_FULL;
					end else begin
						cmd.do_push = 1'b1;
					end
				end else if (sts.kind == qdk_pkg::REQ_POP && sts.is_empty) begin
					cmd.set_status = 1'b1;
					cmd.status_val = qdk_pkg::ST_EMPTY;
				end
			end
			qdk_pkg::S_SEARCH: begin
				cmd.scan = 1'b1;
				if (sts.pend && sts.hit) begin
					cmd.capture = 1'b1;
				end else if (!sts.pend && !sts.more) begin
					cmd.set_status = 1'b1;
					cmd.status_val = qdk_pkg::ST_NOT_FOUND;
				end
			end
			qdk_pkg::S_SHIFT: begin
				cmd.scan     = 1'b1;
				cmd.shift_wr = sts.pend;
				if (!sts.pend && !sts.more) begin
					cmd.dec_count = 1'b1;
				end
			end
			qdk_pkg::S_RESP: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ design/process_queue_delete_by_key.sv @@
// ----------------------------------------------------------------------------
// process_queue_delete_by_key - bounded FIFO of process records with keyed delete
// Top level: request latch, record store, scan pointer, compare and result
// register around the request sequencer.
// ----------------------------------------------------------------------------
// Usage. Requests arrive as beats on the req channel: push, pop, delete by
// pid or delete by name. Every request gives exactly one beat on the rsp
// channel with a status, the removed record (zero when none is removed) and
// the number of records held afterwards.
// Records live in a single RAM with the head at address 0. A pop is a delete
// of the first entry. A delete reads the entries one per cycle from the head
// through the RAM read port and compares each against the key; on a match
// the entries behind it are moved down one place, one per cycle, by the same
// read port feeding the write port.
// A push, a push on a full queue and a failed pop go from start straight to
// the result; a pop or delete walks the held records through the RAM in
// search and, after a match, compaction before its result is shown. The
// next request is taken in the idle state that follows the move of the
// result into the output register.
// Reset empties the queue at once; the RAM contents are not cleared since
// only held entries are ever read. When the receiver stalls the result waits
// in the output register while the next request is still accepted and
// worked on, and that request's result waits until the register is free.
// ----------------------------------------------------------------------------
module process_queue_delete_by_key #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	qdk_req_if.sink  req,
	qdk_rsp_if.source rsp
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qdk_pkg::ctrl_sts_t sts;
	qdk_pkg::ctrl_cmd_t cmd;

	// Request latched at acceptance.
	qdk_pkg::req_kind_t            kind_q;
	logic [qdk_pkg::NAME_W-1:0]    key_name_q;
	logic [qdk_pkg::PID_W-1:0]     key_pid_q;
	qdk_pkg::record_t              push_rec_q;

	// Queue occupancy and scan pointer.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             pend_s1;
	logic [IDX_W-1:0] idx_s1;

	// Result being built, and the output register.
	qdk_pkg::record_t res_rec_q;
	qdk_pkg::status_t res_status_q;
	logic             out_valid_q;
	qdk_pkg::record_t out_rec_q;
	qdk_pkg::status_t out_status_q;
	logic [qdk_pkg::LEFT_W-1:0] out_left_q;

	logic             in_fire;
	logic             more;
	logic             issue;
	logic             hit;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	qdk_pkg::record_t ram_wdata;
	qdk_pkg::record_t ram_rdata;
	logic [qdk_pkg::LEFT_W+CNT_W-1:0] left_ext;

	assign in_fire = req.valid && cmd.in_ready;
	assign more    = (rd_idx_q < count_q);
	assign issue   = cmd.scan && more;

	// A pop takes the head; the deletes compare the key against the stored field.
	always_comb begin
		case (kind_q)
			qdk_pkg::REQ_POP:      hit = 1'b1;
			qdk_pkg::REQ_DEL_PID:  hit = (ram_rdata.pid == key_pid_q);
			qdk_pkg::REQ_DEL_NAME: hit = (ram_rdata.name == key_name_q);
			default:               hit = 1'b0;
		endcase
	end

	always_comb begin
		sts.in_fire  = in_fire;
		sts.kind     = kind_q;
		sts.is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
		sts.is_empty = (count_q == '0);
		sts.pend     = pend_s1;
		sts.hit      = hit;
		sts.more     = more;
		sts.out_free = !out_valid_q || rsp.ready;
	end

	qdk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// The write port serves a push at the tail or a move down by one place.
	assign ram_we    = cmd.do_push || cmd.shift_wr;
	assign ram_waddr = cmd.do_push ? count_q[IDX_W-1:0] : (idx_s1 - IDX_W'(1));
	assign ram_wdata = cmd.do_push ? push_rec_q : ram_rdata;

	qdk_ram #(
		.WIDTH (qdk_pkg::REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q             <= qdk_pkg::req_kind_t'(req.req_type);
			key_name_q         <= qdk_pkg::norm_name(req.in_name);
			key_pid_q          <= req.in_pid;
			push_rec_q.name    <= qdk_pkg::norm_name(req.in_name);
			push_rec_q.prio    <= req.in_priority;
			push_rec_q.pid     <= req.in_pid;
			push_rec_q.runtime <= req.in_runtime;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
		end else begin
			if (cmd.do_push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (in_fire) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			pend_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (in_fire) begin
			res_rec_q    <= '0;
			res_status_q <= qdk_pkg::ST_OK;
		end else begin
			if (cmd.capture) begin
				res_rec_q <= ram_rdata;
			end
			if (cmd.set_status) begin
				res_status_q <= cmd.status_val;
			end
		end
	end

	// Occupancy shown modulo the width of the result field.
	assign left_ext = {{qdk_pkg::LEFT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_rec_q    <= res_rec_q;
			out_status_q <= res_status_q;
			out_left_q   <= left_ext[qdk_pkg::LEFT_W-1:0];
		end
	end

	assign req.ready        = cmd.in_ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.out_name     = out_rec_q.name;
	assign rsp.out_priority = out_rec_q.prio;
	assign rsp.out_pid      = out_rec_q.pid;
	assign rsp.out_runtime  = out_rec_q.runtime;
	assign rsp.entries_left = out_left_q;

endmodule
